>>> rtl/bpc_pkg.sv
package bpc_pkg;

    // Field and port widths
    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int TEMP_W = 20;
    localparam int PRES_W = 27;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Internal widths, sized to hold the value ranges
    localparam int DT_W   = 25;                      // raw temperature minus reference
    localparam int PROD_W = 42;                      // dT times a calibration word
    localparam int DT2_W  = 50;                      // dT squared
    localparam int T_SHIFT  = 23;
    localparam int T2_SHIFT = 31;
    localparam int T2_W   = 17;                      // dT squared >> 31, never negative
    localparam int A_W    = PROD_W - T_SHIFT;        // first-order temperature minus 20.00
    localparam int B_W    = 20;                      // first-order temperature plus 15.00
    localparam int SQ_W   = 38;                      // squares of A and B
    localparam int CORR_W = 40;                      // offset and sensitivity
    localparam int LO_W   = 16;                      // low slice of sensitivity
    localparam int PLO_W  = RAW_W + LO_W;
    localparam int PHI_W  = RAW_W + 1 + CORR_W - LO_W;
    localparam int FULL_W = 64;
    localparam int P1_SHIFT = 21;
    localparam int P2_SHIFT = 15;
    localparam int X_W    = FULL_W - P1_SHIFT + 1;

    localparam int REF_SHIFT  = 8;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int OC_SHIFT   = 16;
    localparam int SC_SHIFT   = 15;

    // Register stages from input register to result register
    localparam int LATENCY = 9;

    localparam logic [TEMP_W-1:0] T_REF  = TEMP_W'(2000);  // 20.00 degrees
    localparam logic [B_W-1:0]    T_COLD = B_W'(3500);     // 20.00 minus -15.00 degrees

    typedef struct packed {
        logic [CAL_W-1:0] sens_coeff;
        logic [CAL_W-1:0] offset_coeff;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temperature;
        logic [CAL_W-1:0] temp_coeff;
    } t_cal;

    // First-order results handed to the second-order correction
    typedef struct packed {
        logic              valid;
        logic [RAW_W-1:0]  d1;
        logic [TEMP_W-1:0] temp;
        logic [CORR_W-1:0] off1;
        logic [CORR_W-1:0] sens1;
        logic [A_W-1:0]    a;
        logic [B_W-1:0]    b;
    } t_fo;

    // Corrected offset and sensitivity handed to the pressure product
    typedef struct packed {
        logic              valid;
        logic [RAW_W-1:0]  d1;
        logic [TEMP_W-1:0] temp;
        logic [CORR_W-1:0] off;
        logic [CORR_W-1:0] sens;
    } t_so;

endpackage

>>> rtl/bpc_regs.sv
module bpc_regs
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cal              o_cal
);

    typedef enum logic [2:0] {
        REG_SENS_COEFF,
        REG_OFFSET_COEFF,
        REG_SENS_TEMPCO,
        REG_OFFSET_TEMPCO,
        REG_REF_TEMPERATURE,
        REG_TEMP_COEFF
    } t_reg;

    t_cal r_cal;
    t_cal n_cal;
    t_reg idx;
    logic wr_en;

    assign idx    = t_reg'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cal = r_cal;
        if (wr_en) begin
            case (idx)
                REG_SENS_COEFF:      n_cal.sens_coeff      = pwdata[CAL_W-1:0];
                REG_OFFSET_COEFF:    n_cal.offset_coeff    = pwdata[CAL_W-1:0];
                REG_SENS_TEMPCO:     n_cal.sens_tempco     = pwdata[CAL_W-1:0];
                REG_OFFSET_TEMPCO:   n_cal.offset_tempco   = pwdata[CAL_W-1:0];
                REG_REF_TEMPERATURE: n_cal.ref_temperature = pwdata[CAL_W-1:0];
                REG_TEMP_COEFF:      n_cal.temp_coeff      = pwdata[CAL_W-1:0];
                default:             n_cal = r_cal;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SENS_COEFF:      prdata = DATA_W'(r_cal.sens_coeff);
            REG_OFFSET_COEFF:    prdata = DATA_W'(r_cal.offset_coeff);
            REG_SENS_TEMPCO:     prdata = DATA_W'(r_cal.sens_tempco);
            REG_OFFSET_TEMPCO:   prdata = DATA_W'(r_cal.offset_tempco);
            REG_REF_TEMPERATURE: prdata = DATA_W'(r_cal.ref_temperature);
            REG_TEMP_COEFF:      prdata = DATA_W'(r_cal.temp_coeff);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

>>> rtl/bpc_first_order.sv
module bpc_first_order
    import bpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    input  t_cal             i_cal,
    output t_fo              o_fo
);

    // Stage 1: dT
    logic              r1_valid;
    logic [RAW_W-1:0]  r1_d1;
    logic [DT_W-1:0]   r1_dt;
    logic [DT_W-1:0]   n1_dt;

    // Stage 2: products with dT
    logic              r2_valid;
    logic [RAW_W-1:0]  r2_d1;
    logic [PROD_W-1:0] r2_tc;
    logic [PROD_W-1:0] r2_offt;
    logic [PROD_W-1:0] r2_senst;
    logic [DT2_W-1:0]  r2_dt2;
    logic [PROD_W-1:0] dt_ext;
    logic [DT2_W-1:0]  dt_sq_ext;

    // Stage 3: first-order sums
    t_fo               r3;
    logic [A_W-1:0]    n3_a;
    logic [T2_W-1:0]   n3_t2;
    logic [TEMP_W-1:0] n3_a_ext;

    assign n1_dt = {1'b0, i_raw_temperature}
                 - {1'b0, i_cal.ref_temperature, {REF_SHIFT{1'b0}}};

    assign dt_ext    = {{(PROD_W-DT_W){r1_dt[DT_W-1]}}, r1_dt};
    assign dt_sq_ext = {{(DT2_W-DT_W){r1_dt[DT_W-1]}}, r1_dt};

    assign n3_a     = r2_tc[PROD_W-1:T_SHIFT];
    assign n3_t2    = r2_dt2[T2_SHIFT +: T2_W];
    assign n3_a_ext = {{(TEMP_W-A_W){n3_a[A_W-1]}}, n3_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3.valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3.valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d1 <= i_raw_pressure;
        r1_dt <= n1_dt;

        r2_d1    <= r1_d1;
        r2_tc    <= dt_ext * PROD_W'(i_cal.temp_coeff);
        r2_offt  <= dt_ext * PROD_W'(i_cal.offset_tempco);
        r2_senst <= dt_ext * PROD_W'(i_cal.sens_tempco);
        r2_dt2   <= dt_sq_ext * dt_sq_ext;

        r3.d1    <= r2_d1;
        r3.a     <= n3_a;
        r3.b     <= {{(B_W-A_W){n3_a[A_W-1]}}, n3_a} + T_COLD;
        // The dT squared term applies only below 20.00 degrees
        r3.temp  <= n3_a_ext + T_REF - (n3_a[A_W-1] ? TEMP_W'(n3_t2) : '0);
        r3.off1  <= CORR_W'({i_cal.offset_coeff, {OC_SHIFT{1'b0}}})
                  + {{(CORR_W-PROD_W+OFF_SHIFT){r2_offt[PROD_W-1]}},
                     r2_offt[PROD_W-1:OFF_SHIFT]};
        r3.sens1 <= CORR_W'({i_cal.sens_coeff, {SC_SHIFT{1'b0}}})
                  + {{(CORR_W-PROD_W+SENS_SHIFT){r2_senst[PROD_W-1]}},
                     r2_senst[PROD_W-1:SENS_SHIFT]};
    end

    assign o_fo = r3;

endmodule

>>> rtl/bpc_second_order.sv
module bpc_second_order
    import bpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_fo  i_fo,
    output t_so  o_so
);

    // Stage 4: squares
    logic              r4_valid;
    logic [RAW_W-1:0]  r4_d1;
    logic [TEMP_W-1:0] r4_temp;
    logic [CORR_W-1:0] r4_off1;
    logic [CORR_W-1:0] r4_sens1;
    logic [SQ_W-1:0]   r4_a2;
    logic [SQ_W-1:0]   r4_b2;
    logic              r4_cold;
    logic              r4_vcold;
    logic [SQ_W-1:0]   a_ext;
    logic [SQ_W-1:0]   b_ext;

    // Stage 5: constant multiples, zero in the warm range
    logic              r5_valid;
    logic [RAW_W-1:0]  r5_d1;
    logic [TEMP_W-1:0] r5_temp;
    logic [CORR_W-1:0] r5_off1;
    logic [CORR_W-1:0] r5_sens1;
    logic [CORR_W-1:0] r5_a5;
    logic [CORR_W-1:0] r5_b7;
    logic [CORR_W-1:0] r5_b11;
    logic [CORR_W-1:0] a2_w;
    logic [CORR_W-1:0] b2_w;

    // Stage 6: corrected offset and sensitivity
    t_so               r6;

    assign a_ext = {{(SQ_W-A_W){i_fo.a[A_W-1]}}, i_fo.a};
    assign b_ext = {{(SQ_W-B_W){i_fo.b[B_W-1]}}, i_fo.b};
    assign a2_w  = CORR_W'(r4_a2);
    assign b2_w  = CORR_W'(r4_b2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6.valid <= 1'b0;
        end else begin
            r4_valid <= i_fo.valid;
            r5_valid <= r4_valid;
            r6.valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_d1    <= i_fo.d1;
        r4_temp  <= i_fo.temp;
        r4_off1  <= i_fo.off1;
        r4_sens1 <= i_fo.sens1;
        r4_a2    <= a_ext * a_ext;
        r4_b2    <= b_ext * b_ext;
        r4_cold  <= i_fo.a[A_W-1];
        r4_vcold <= i_fo.b[B_W-1];

        r5_d1    <= r4_d1;
        r5_temp  <= r4_temp;
        r5_off1  <= r4_off1;
        r5_sens1 <= r4_sens1;
        r5_a5    <= r4_cold  ? a2_w + (a2_w << 2) : '0;
        r5_b7    <= r4_vcold ? (b2_w << 3) - b2_w : '0;
        r5_b11   <= r4_vcold ? (b2_w << 3) + (b2_w << 1) + b2_w : '0;

        // Both terms are never negative, so plain shifts floor them
        r6.d1   <= r5_d1;
        r6.temp <= r5_temp;
        r6.off  <= r5_off1 - (r5_a5 >> 1) - r5_b7;
        r6.sens <= r5_sens1 - (r5_a5 >> 2) - (r5_b11 >> 1);
    end

    assign o_so = r6;

endmodule

>>> rtl/bpc_pres_mul.sv
module bpc_pres_mul
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_so               i_so,
    output logic              o_strobe,
    output logic [TEMP_W-1:0] o_temperature,
    output logic [PRES_W-1:0] o_pressure
);

    // Stage 7: partial products of D1 and sensitivity
    logic              r7_valid;
    logic [TEMP_W-1:0] r7_temp;
    logic [CORR_W-1:0] r7_off;
    logic [PLO_W-1:0]  r7_plo;
    logic [PHI_W-1:0]  r7_phi;
    logic [PHI_W-1:0]  d1_ext;
    logic [PHI_W-1:0]  sens_hi_ext;

    // Stage 8: full product
    logic              r8_valid;
    logic [TEMP_W-1:0] r8_temp;
    logic [CORR_W-1:0] r8_off;
    logic [FULL_W-1:0] r8_prod;

    // Stage 9: result register
    logic              r9_strobe;
    logic [TEMP_W-1:0] r9_temp;
    logic [PRES_W-1:0] r9_pres;
    logic [X_W-1:0]    diff;

    assign d1_ext      = PHI_W'(i_so.d1);
    assign sens_hi_ext = {{(PHI_W-CORR_W+LO_W){i_so.sens[CORR_W-1]}},
                          i_so.sens[CORR_W-1:LO_W]};

    assign diff = {{(X_W-FULL_W+P1_SHIFT){r8_prod[FULL_W-1]}}, r8_prod[FULL_W-1:P1_SHIFT]}
                - {{(X_W-CORR_W){r8_off[CORR_W-1]}}, r8_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_strobe <= 1'b0;
        end else begin
            r7_valid  <= i_so.valid;
            r8_valid  <= r7_valid;
            r9_strobe <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_temp <= i_so.temp;
        r7_off  <= i_so.off;
        r7_plo  <= PLO_W'(i_so.d1) * PLO_W'(i_so.sens[LO_W-1:0]);
        r7_phi  <= d1_ext * sens_hi_ext;

        r8_temp <= r7_temp;
        r8_off  <= r7_off;
        r8_prod <= FULL_W'({r7_phi, {LO_W{1'b0}}}) + FULL_W'(r7_plo);

        r9_temp <= r8_temp;
        r9_pres <= diff[P2_SHIFT +: PRES_W];
    end

    assign o_strobe      = r9_strobe;
    assign o_temperature = r9_temp;
    assign o_pressure    = r9_pres;

endmodule

>>> rtl/barometric_pressure_compensation_unit.sv
// Second-order barometric pressure and temperature compensation.
//
// Input channel: drive start high with a raw pressure and a raw temperature
// conversion; the transaction is taken at that clock edge. busy stays low, so
// a new pair can be presented in every cycle.
// Output channel: o_strobe marks one cycle in which o_temperature (0.01 degC)
// and o_pressure (0.01 mbar) hold the result of one input transaction. The
// receiver cannot stall: the result is there for exactly that one cycle.
// Results leave in the order the inputs came in.
// Throughput is one transaction per clock. Each transaction passes in order
// through nine register stages: dT, the dT products, the first-order sums,
// the squares, the constant multiples, the corrected offset and sensitivity,
// the two partial products of D1 times sensitivity, their sum, and the result.
// Calibration: six 16-bit words on the APB port at byte addresses 0 to 20;
// write them only while no transaction is in flight. Reset (synchronous, low)
// clears the calibration words to zero and drops every transaction in flight.
module barometric_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    output logic                     o_strobe,
    output logic signed [TEMP_W-1:0] o_temperature,
    output logic signed [PRES_W-1:0] o_pressure,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_cal cal;
    t_fo  fo;
    t_so  so;
    logic              in_take;
    logic [TEMP_W-1:0] res_temp;
    logic [PRES_W-1:0] res_pres;

    // The pipeline never holds off an input
    assign busy    = 1'b0;
    assign in_take = start && !busy;

    // Calibration register file
    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (cal)
    );

    // dT, first-order temperature, offset and sensitivity
    bpc_first_order u_first (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_take),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (cal),
        .o_fo              (fo)
    );

    // Cold-range correction of offset and sensitivity
    bpc_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fo    (fo),
        .o_so    (so)
    );

    // Pressure from D1 times sensitivity, minus offset
    bpc_pres_mul u_pres (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_so          (so),
        .o_strobe      (o_strobe),
        .o_temperature (res_temp),
        .o_pressure    (res_pres)
    );

    assign o_temperature = res_temp;
    assign o_pressure    = res_pres;

endmodule

>>> rtl/bpc_checker.sv
module bpc_checker
    import bpc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_strobe,
    input logic signed [TEMP_W-1:0] o_temperature
);

    // Every accepted transaction yields a result after the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result missing after accepted transaction");

    // No result appears without a matching accepted transaction
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_strobe)
        else $error("result without matching transaction");

    // The pipeline takes a transaction in every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // Temperature stays inside the sensor's reachable range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_temperature >= -20'sd300000 && o_temperature <= 20'sd300000))
        else $error("temperature out of range");

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_temperature (o_temperature)
);

>>> tb/tb_barometric_pressure_compensation_unit.sv
module tb_barometric_pressure_compensation_unit;
    import bpc_pkg::*;

    // Calibration register map, one 32-bit word per register
    typedef enum int unsigned {
        CAL_SENS_COEFF,
        CAL_OFFSET_COEFF,
        CAL_SENS_TEMPCO,
        CAL_OFFSET_TEMPCO,
        CAL_REF_TEMPERATURE,
        CAL_TEMP_COEFF
    } cal_reg_e;

    typedef struct {
        logic [TEMP_W-1:0] temperature;
        logic [PRES_W-1:0] pressure;
    } compensated_reading_t;

    // Second-order correction starts below 20.00 degC, extra term below -15.00 degC
    localparam longint WARM_THRESHOLD     = 2000;
    localparam longint COLD_THRESHOLD     = -1500;
    localparam int     WATCHDOG_LIMIT     = 2000;
    localparam int     RANDOM_PHASE_ITEMS = 305;
    localparam int     DEFAULT_IDLE_PCT   = 38;

    // Predict each reading from the accepted conversion pair and hold the
    // predictions in arrival order; compare every strobed result with the oldest.
    class reading_scoreboard;
        t_cal                 cal;
        compensated_reading_t pending_readings[$];
        int unsigned          mismatches;

        function new();
            cal        = '0;
            mismatches = 0;
        endfunction

        function void set_cal(cal_reg_e idx, logic [CAL_W-1:0] value);
            case (idx)
                CAL_SENS_COEFF:      cal.sens_coeff      = value;
                CAL_OFFSET_COEFF:    cal.offset_coeff    = value;
                CAL_SENS_TEMPCO:     cal.sens_tempco     = value;
                CAL_OFFSET_TEMPCO:   cal.offset_tempco   = value;
                CAL_REF_TEMPERATURE: cal.ref_temperature = value;
                CAL_TEMP_COEFF:      cal.temp_coeff      = value;
                default: ;
            endcase
        endfunction

        function compensated_reading_t compensate(logic [RAW_W-1:0] d1,
                                                  logic [RAW_W-1:0] d2);
            longint dt, t1, t2, a, b, off2, sens2, off, sens, pres;
            compensated_reading_t r;
            dt    = longint'(d2) - (longint'(cal.ref_temperature) <<< REF_SHIFT);
            t1    = WARM_THRESHOLD + ((dt * longint'(cal.temp_coeff)) >>> T_SHIFT);
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            // Below 20.00 degC: square-law correction of temperature, offset, sensitivity
            if (t1 < WARM_THRESHOLD) begin
                a     = t1 - WARM_THRESHOLD;
                t2    = (dt * dt) >>> T2_SHIFT;
                off2  = (5 * a * a) / 2;
                sens2 = (5 * a * a) / 4;
                // Very cold: add the second square term
                if (t1 < COLD_THRESHOLD) begin
                    b     = t1 - COLD_THRESHOLD;
                    off2  = off2 + 7 * b * b;
                    sens2 = sens2 + (11 * b * b) / 2;
                end
            end
            off  = (longint'(cal.offset_coeff) <<< OC_SHIFT)
                 + ((longint'(cal.offset_tempco) * dt) >>> OFF_SHIFT) - off2;
            sens = (longint'(cal.sens_coeff) <<< SC_SHIFT)
                 + ((longint'(cal.sens_tempco) * dt) >>> SENS_SHIFT) - sens2;
            pres = (((longint'(d1) * sens) >>> P1_SHIFT) - off) >>> P2_SHIFT;
            r.temperature = TEMP_W'(t1 - t2);
            r.pressure    = PRES_W'(pres);
            return r;
        endfunction

        function void note_conversion(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            pending_readings.push_back(compensate(d1, d2));
        endfunction

        function void check_reading(logic [TEMP_W-1:0] temperature,
                                    logic [PRES_W-1:0] pressure);
            compensated_reading_t want;
            if (pending_readings.size() == 0) begin
                $error("result with no conversion pending: temperature %0d, pressure %0d",
                       $signed(temperature), $signed(pressure));
                mismatches++;
                return;
            end
            want = pending_readings.pop_front();
            if (temperature !== want.temperature) begin
                $error("temperature: expected %0d, actual %0d",
                       $signed(want.temperature), $signed(temperature));
                mismatches++;
            end
            if (pressure !== want.pressure) begin
                $error("pressure: expected %0d, actual %0d",
                       $signed(want.pressure), $signed(pressure));
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_readings.size();
        endfunction
    endclass

    // Every block input is known from time zero
    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     start             = 1'b0;
    logic                     busy;
    logic [RAW_W-1:0]         i_raw_pressure    = '0;
    logic [RAW_W-1:0]         i_raw_temperature = '0;
    logic                     o_strobe;
    logic signed [TEMP_W-1:0] o_temperature;
    logic signed [PRES_W-1:0] o_pressure;
    logic                     psel              = 1'b0;
    logic                     penable           = 1'b0;
    logic                     pwrite            = 1'b0;
    logic [ADDR_W-1:0]        paddr             = '0;
    logic [DATA_W-1:0]        pwdata            = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    reading_scoreboard sb;
    int unsigned       idle_pct     = DEFAULT_IDLE_PCT;
    int unsigned       quiet_cycles = 0;

    barometric_pressure_compensation_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_strobe          (o_strobe),
        .o_temperature     (o_temperature),
        .o_pressure        (o_pressure),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Results cannot be held off: take every strobed cycle as a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_reading(o_temperature, o_pressure);
        end
    end

    // Count cycles in which no transaction of any kind moves; give up at the limit
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // APB write: setup cycle, access cycle, then release the bus for one cycle
    // so back-to-back writes never lower and raise psel in the same step.
    task automatic write_cal(cal_reg_e idx, logic [CAL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_cal(idx, value);
        @(posedge i_clk);
    endtask

    task automatic load_cal(t_cal c);
        write_cal(CAL_SENS_COEFF,      c.sens_coeff);
        write_cal(CAL_OFFSET_COEFF,    c.offset_coeff);
        write_cal(CAL_SENS_TEMPCO,     c.sens_tempco);
        write_cal(CAL_OFFSET_TEMPCO,   c.offset_tempco);
        write_cal(CAL_REF_TEMPERATURE, c.ref_temperature);
        write_cal(CAL_TEMP_COEFF,      c.temp_coeff);
    endtask

    // Idle at random, then present the pair and hold it until it is taken.
    // start is left high so the next pair can follow without a gap.
    task automatic send_conversion(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_raw_pressure    <= d1;
        i_raw_temperature <= d2;
        do @(posedge i_clk); while (busy);
        sb.note_conversion(d1, d2);
    endtask

    // Drop start and hold until every predicted reading has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Mostly land near the reference point so all three temperature ranges
    // are reached, with some full-range and extreme values mixed in.
    function automatic logic [RAW_W-1:0] pick_raw_temperature(logic [CAL_W-1:0] ref_word);
        longint centre, span, v;
        centre = longint'(ref_word) <<< REF_SHIFT;
        span   = longint'(1) <<< $urandom_range(2, 23);
        v      = centre + longint'($urandom_range(0, int'(2 * span))) - span;
        case ($urandom_range(0, 9))
            0, 1: return RAW_W'($urandom);
            2:    return $urandom_range(0, 1) ? '1 : '0;
            default: begin
                if (v < 0) v = 0;
                if (v > longint'({RAW_W{1'b1}})) v = longint'({RAW_W{1'b1}});
                return RAW_W'(v);
            end
        endcase
    endfunction

    function automatic logic [CAL_W-1:0] pick_cal_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    initial begin
        t_cal typical_cal;
        t_cal c;
        sb          = new();
        typical_cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: all words zero
        send_conversion('0, '0);
        send_conversion('1, '1);
        send_conversion('1, '0);
        send_conversion('0, '1);
        wait_drained();

        // Typical calibration: reference point at raw temperature 8566784
        load_cal(typical_cal);
        send_conversion(24'd9085466, 24'd8569150);
        send_conversion(24'd9085466, 24'd8566784);  // exactly 20.00 degC, warm
        send_conversion(24'd9085466, 24'd8566783);  // just below 20.00 degC
        send_conversion(24'd9085466, 24'd8066784);  // cold
        send_conversion(24'd9085466, 24'd7529764);  // exactly -15.00 degC
        send_conversion(24'd9085466, 24'd7529763);  // just below -15.00 degC
        send_conversion('0, '0);
        send_conversion('1, '0);
        send_conversion('1, '1);
        send_conversion('0, '1);
        send_conversion(24'h555555, 24'hAAAAAA);
        send_conversion(24'hAAAAAA, 24'h555555);
        wait_drained();

        // All calibration words at their maximum
        load_cal('1);
        send_conversion('0, '0);
        send_conversion('1, '0);
        send_conversion('1, '1);
        send_conversion('0, '1);
        send_conversion(24'h800000, 24'hFFFF00);
        send_conversion(24'h800000, 24'hFFFEFF);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: c = typical_cal;
                1: c = '1;
                2: c = '0;
                default: begin
                    c.sens_coeff      = pick_cal_word();
                    c.offset_coeff    = pick_cal_word();
                    c.sens_tempco     = pick_cal_word();
                    c.offset_tempco   = pick_cal_word();
                    c.ref_temperature = pick_cal_word();
                    c.temp_coeff      = (p == 5) ? '1 : pick_cal_word();
                end
            endcase
            load_cal(c);
            for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
                // Run back to back for a long stretch in one phase
                idle_pct = (p == 1 && i >= 60 && i < 200) ? 0 : DEFAULT_IDLE_PCT;
                // Starve the pipeline completely once
                if (p == 2 && i == 150) wait_drained();
                send_conversion(pick_raw_pressure(),
                                pick_raw_temperature(sb.cal.ref_temperature));
            end
            wait_drained();
        end

        // Catch any stray strobe after the last expected reading
        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/bpc_pkg.sv
rtl/bpc_regs.sv
rtl/bpc_first_order.sv
rtl/bpc_second_order.sv
rtl/bpc_pres_mul.sv
rtl/barometric_pressure_compensation_unit.sv
rtl/bpc_checker.sv
tb/tb_barometric_pressure_compensation_unit.sv
